### sv/top_k_score_selector_assert.svh
// Assertion helpers shared by the selector RTL.
// Both sample on clk and are disabled while rst is high.
`ifndef TOP_K_SCORE_SELECTOR_ASSERT_SVH
`define TOP_K_SCORE_SELECTOR_ASSERT_SVH

// same-cycle implication
`define TKS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("top_k_score_selector: assertion failed");

// next-cycle implication
`define TKS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("top_k_score_selector: assertion failed");

`endif

### sv/tks_pkg.sv
`default_nettype none

package tks_pkg;

  localparam int SCORE_W = 8;
  localparam int IDX_W   = 10;
  localparam int LEN_W   = 3;
  localparam int RANK_W  = 3;

  // control from the input stage to the list
  typedef struct packed {
    logic step;  // an item is processed this cycle
    logic last;  // that item closes the vector
  } list_ctrl_t;

endpackage

`default_nettype wire

### sv/top_k_score_selector.sv
// Streaming top-k score selector.
// Input channel (in_valid/in_stall): one score per beat with true_class and
// vector_end; a beat is taken when in_valid is high and in_stall is low.
// Output channel (out_valid/out_stall): one ranked entry per beat, best first,
// final_entry on the last; only as many entries as scores arrived, at most
// the list length. Config channel (cfg_valid/cfg_ready, cfg_data) writes the
// list length; cfg_ready is always high. Write it only while idle.
// A score is first held in the input register, then inserted into the list;
// on the last score the list moves to the emit buffer, and its first entry is
// valid once that load is done.
// Throughput: one score per cycle unless in_stall is high; the buffer drains
// one entry a cycle unless out_stall is high, so a vector end that arrives
// while it still drains waits for its final beat, which holds in_stall high.
// Reset: list empty, position zero, list length 5, no output pending.
// A stalled output holds its entry; scores of the next vector keep flowing
// until that vector's end needs the buffer.
`default_nettype none
`include "top_k_score_selector_assert.svh"

module top_k_score_selector #(
  parameter int TOP_K      = 5,
  parameter int MAX_SCORES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tks_pkg::SCORE_W-1:0] score,
  input  logic [tks_pkg::IDX_W-1:0]   true_class,
  input  logic                        vector_end,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tks_pkg::LEN_W-1:0]   cfg_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tks_pkg::IDX_W-1:0]   class_index,
  output logic [tks_pkg::SCORE_W-1:0] confidence,
  output logic [tks_pkg::RANK_W-1:0]  rank,
  output logic                        final_entry,
  output logic                        top1_hit,
  output logic                        list_hit
);
  import tks_pkg::*;

  localparam int CNT_W = $clog2(TOP_K + 1);
  localparam int K_W   = (TOP_K > 1) ? $clog2(TOP_K) : 1;

  logic [LEN_W-1:0] list_length;
  logic [CNT_W-1:0] len;

  // input register
  logic               in_r_valid;
  logic [SCORE_W-1:0] score_r;
  logic [IDX_W-1:0]   tc_r;
  logic               last_r;

  list_ctrl_t         ctrl;
  logic [SCORE_W-1:0] scores_next [TOP_K];
  logic [IDX_W-1:0]   idx_next [TOP_K];
  logic [CNT_W-1:0]   fill_next;

  // emit buffer
  logic               busy;
  logic [SCORE_W-1:0] buf_scores [TOP_K];
  logic [IDX_W-1:0]   buf_idx [TOP_K];
  logic [CNT_W-1:0]   buf_n;
  logic [K_W-1:0]     buf_k;
  logic               buf_top1;
  logic               buf_hit;

  logic             take;
  logic             last_taken;
  logic             proc;
  logic             load;
  logic [TOP_K-1:0] match;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= LEN_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      list_length <= cfg_data;
    end
  end

  always_comb begin
    if (list_length == '0) begin
      len = CNT_W'(1);
    end else if (int'(list_length) > TOP_K) begin
      len = CNT_W'(TOP_K);
    end else begin
      len = CNT_W'(list_length);
    end
  end

  assign out_valid   = busy;
  assign class_index = buf_idx[buf_k];
  assign confidence  = buf_scores[buf_k];
  assign rank        = RANK_W'(buf_k);
  assign final_entry = (CNT_W'(buf_k) == buf_n - CNT_W'(1));
  assign top1_hit    = buf_top1;
  assign list_hit    = buf_hit;

  assign take       = out_valid && !out_stall;
  assign last_taken = take && final_entry;

  // a vector end needs the emit buffer free, or freeing on this edge
  assign proc     = in_r_valid && (!last_r || !busy || last_taken);
  assign load     = proc && last_r && (fill_next != '0);
  assign in_stall = in_r_valid && !proc;

  assign ctrl.step = proc;
  assign ctrl.last = last_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_r_valid <= 1'b0;
    end else if (!in_stall) begin
      in_r_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      score_r <= score;
      tc_r    <= true_class;
      last_r  <= vector_end;
    end
  end

  tks_list #(
    .TOP_K      (TOP_K),
    .MAX_SCORES (MAX_SCORES)
  ) u_list (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .score       (score_r),
    .len         (len),
    .scores_next (scores_next),
    .idx_next    (idx_next),
    .fill_next   (fill_next)
  );

  always_comb begin
    for (int j = 0; j < TOP_K; j++) begin
      match[j] = (CNT_W'(j) < fill_next) && (idx_next[j] == tc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      buf_k <= '0;
    end else if (load) begin
      busy  <= 1'b1;
      buf_k <= '0;
    end else if (take) begin
      if (final_entry) begin
        busy <= 1'b0;
      end else begin
        buf_k <= buf_k + K_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_scores <= scores_next;
      buf_idx    <= idx_next;
      buf_n      <= fill_next;
      buf_top1   <= match[0];
      buf_hit    <= |match;
    end
  end

  `TKS_ASSERT_NOW(a_drain_in_range, out_valid, (CNT_W'(buf_k) < buf_n))
  `TKS_ASSERT_NOW(a_no_overwrite, load, (!busy || last_taken))
  `TKS_ASSERT_NEXT(a_drain_ends, (last_taken && !load), !out_valid)
  `TKS_ASSERT_NEXT(a_load_starts_at_top, load, (out_valid && buf_k == '0))

endmodule

`default_nettype wire

### sv/tks_list.sv
`default_nettype none

module tks_list #(
  parameter int TOP_K      = 5,
  parameter int MAX_SCORES = 1024,
  localparam int CNT_W     = $clog2(TOP_K + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tks_pkg::list_ctrl_t         ctrl,
  input  logic [tks_pkg::SCORE_W-1:0] score,
  input  logic [CNT_W-1:0]            len,
  output logic [tks_pkg::SCORE_W-1:0] scores_next [TOP_K],
  output logic [tks_pkg::IDX_W-1:0]   idx_next [TOP_K],
  output logic [CNT_W-1:0]            fill_next
);
  import tks_pkg::*;

  localparam int POS_W = $clog2(MAX_SCORES + 1);

  logic [SCORE_W-1:0] scores [TOP_K];
  logic [IDX_W-1:0]   idx [TOP_K];
  logic [CNT_W-1:0]   fill;
  logic [POS_W-1:0]   pos;

  logic [CNT_W-1:0] fill_eff;
  logic             pos_ok;
  logic [IDX_W-1:0] new_idx;
  logic [TOP_K-1:0] gt;
  logic [TOP_K-1:0] ins;
  logic             run;

  // a shortened length drops the tail of the list
  assign fill_eff = (fill > len) ? len : fill;
  assign pos_ok   = pos < POS_W'(MAX_SCORES);
  assign new_idx  = IDX_W'(pos);

  // ins marks entries at or after the insertion slot, within the length, while pos is below MAX_SCORES
  always_comb begin
    run = 1'b0;
    for (int j = 0; j < TOP_K; j++) begin
      gt[j]  = (CNT_W'(j) < fill_eff) && (score > scores[j]);
      run    = run | gt[j] | (CNT_W'(j) == fill_eff);
      ins[j] = run && pos_ok && (CNT_W'(j) < len);
    end
  end

  for (genvar j = 0; j < TOP_K; j++) begin : g_entry
    if (j == 0) begin : g_head
      always_comb begin
        if (ins[0]) begin
          scores_next[0] = score;
          idx_next[0]    = new_idx;
        end else begin
          scores_next[0] = scores[0];
          idx_next[0]    = idx[0];
        end
      end
    end else begin : g_body
      always_comb begin
        if (ins[j] && ins[j-1]) begin
          scores_next[j] = scores[j-1];
          idx_next[j]    = idx[j-1];
        end else if (ins[j]) begin
          scores_next[j] = score;
          idx_next[j]    = new_idx;
        end else begin
          scores_next[j] = scores[j];
          idx_next[j]    = idx[j];
        end
      end
    end
  end

  assign fill_next = fill_eff + CNT_W'((|ins) && (fill_eff < len));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      pos  <= '0;
    end else if (ctrl.step) begin
      if (ctrl.last) begin
        fill <= '0;
        pos  <= '0;
      end else begin
        fill <= fill_next;
        pos  <= pos + POS_W'(pos_ok);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      scores <= scores_next;
      idx    <= idx_next;
    end
  end

endmodule

`default_nettype wire
